>>> design/srwc_pkg.sv
package srwc_pkg;

	// Field widths of the request and response transactions.
	localparam int unsigned POS_W  = 40;   // source byte offsets and sizes
	localparam int unsigned END_W  = POS_W + 1; // offset plus a length, never wraps
	localparam int unsigned LEN_W  = 17;   // request lengths
	localparam int unsigned BUF_W  = 19;   // window buffer indexes and sizes

	// Window geometry. CHUNK_BYTES must be a power of two.
	localparam int unsigned CHUNK_BYTES = 32768;
	localparam int unsigned WINDOW_MAX  = 262144;
	localparam int unsigned MAX_REQUEST = 65536;

	localparam logic [POS_W-1:0] BACKOFF      = POS_W'(2 * CHUNK_BYTES);
	localparam logic [POS_W-1:0] CHUNK_MASK   = ~(POS_W'(CHUNK_BYTES - 1));
	localparam logic [END_W-1:0] WIN_MAX_END  = END_W'(WINDOW_MAX);
	localparam logic [BUF_W-1:0] WIN_MAX_SIZE = BUF_W'(WINDOW_MAX);
	localparam logic [LEN_W-1:0] REQ_LIMIT    = LEN_W'(MAX_REQUEST);

	typedef enum logic [1:0] {
		STATUS_EMPTY  = 2'd0,
		STATUS_HIT    = 2'd1,
		STATUS_REFILL = 2'd2
	} status_t;

	typedef struct packed {
		logic [POS_W-1:0] req_offset;
		logic [LEN_W-1:0] req_len;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [BUF_W-1:0] buffer_index;
		logic [LEN_W-1:0] avail_len;
		logic [POS_W-1:0] new_window_start;
		logic [BUF_W-1:0] new_window_size;
		logic [BUF_W-1:0] keep_src;
		logic [BUF_W-1:0] keep_count;
		logic             seek_needed;
		logic [POS_W-1:0] read_pos;
		logic [BUF_W-1:0] read_dest;
		logic [BUF_W-1:0] read_count;
	} rsp_t;

	// Everything about a request that does not depend on the current window.
	typedef struct packed {
		logic             empty;
		logic [POS_W-1:0] offset;
		logic [LEN_W-1:0] avail_len;
		logic [END_W-1:0] req_end;
		logic [POS_W-1:0] win_start;
		logic [BUF_W-1:0] win_size;
		logic [END_W-1:0] win_end;
		logic [BUF_W-1:0] buf_off;
	} plan_t;

endpackage

>>> design/srwc_plan.sv
module srwc_plan (
	input  srwc_pkg::req_t            req,
	input  logic [srwc_pkg::POS_W-1:0] src_size,
	output srwc_pkg::plan_t           plan
);
	import srwc_pkg::*;

	logic [LEN_W-1:0] len_sat;
	logic [POS_W-1:0] remain;
	logic [LEN_W-1:0] len_clip;
	logic [END_W-1:0] req_end;
	logic [POS_W-1:0] ws;
	logic [END_W-1:0] ws_max_end;
	logic [BUF_W-1:0] wsz_cap;
	logic [END_W-1:0] ws_end_cap;

	always_comb begin
		len_sat = (req.req_len > REQ_LIMIT) ? REQ_LIMIT : req.req_len;
		remain  = src_size - req.req_offset;
		if (req.req_offset >= src_size) begin
			len_clip = '0;
		end else if ({{(POS_W-LEN_W){1'b0}}, len_sat} > remain) begin
			len_clip = remain[LEN_W-1:0];
		end else begin
			len_clip = len_sat;
		end
		req_end = {1'b0, req.req_offset} + END_W'(len_clip);

		// New window opens two chunks back, aligned down to a chunk boundary.
		if (req.req_offset > BACKOFF) begin
			ws = (req.req_offset - BACKOFF) & CHUNK_MASK;
		end else begin
			ws = '0;
		end

		// Full-size window unless it runs past the end of the source.
		ws_max_end = {1'b0, ws} + WIN_MAX_END;
		if (ws_max_end > {1'b0, src_size}) begin
			wsz_cap = (src_size > ws) ? BUF_W'(src_size - ws) : '0;
		end else begin
			wsz_cap = WIN_MAX_SIZE;
		end
		ws_end_cap = {1'b0, ws} + END_W'(wsz_cap);

		plan.empty     = (req.req_len == '0);
		plan.offset    = req.req_offset;
		plan.avail_len = len_clip;
		plan.req_end   = req_end;
		plan.win_start = ws;
		plan.buf_off   = BUF_W'(req.req_offset - ws);
		// The window always grows to cover the whole requested region.
		if (req_end > ws_end_cap) begin
			plan.win_size = BUF_W'(req_end - {1'b0, ws});
			plan.win_end  = req_end;
		end else begin
			plan.win_size = wsz_cap;
			plan.win_end  = ws_end_cap;
		end
	end

endmodule

>>> design/sliding_read_window_controller.sv
// Sliding read-window controller.
// Requests (offset, length) arrive on the req channel and one response per
// request leaves on the rsp channel, in order. A transaction moves on a
// channel at a rising clock edge where valid is high and stall is low.
// The response reports an empty request, a hit in the buffered window, or a
// refill: the new window, a move command that keeps the overlapping tail of
// the old window, and a read command with a seek flag.
// The user must write the source size through cfg_wr_en / cfg_wr_data only
// while idle; the block does not enforce this. A request passes through
// req_s1, plan_s2 and rsp_s3. Throughput: one transaction per cycle while rsp
// does not stall, set by the window state loop in the second stage, which sees
// the window left by the previous request. A stall on rsp holds every stage
// in place and raises req_stall in the same cycle only once the response
// register is occupied. Reset clears the source size, the window (base,
// length, end) and the source position to zero and empties the pipeline.
module sliding_read_window_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [srwc_pkg::POS_W-1:0]  cfg_wr_data,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  srwc_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output srwc_pkg::rsp_t              rsp
);
	import srwc_pkg::*;

	// All stages move together whenever the response register can take data.
	logic advance;

	logic [POS_W-1:0] src_size_q;

	logic   valid_s1;
	req_t   req_s1;
	plan_t  plan_comb;
	logic   valid_s2;
	plan_t  plan_s2;
	logic   valid_s3;
	rsp_t   rsp_s3;
	rsp_t   rsp_next;

	// Window state. The end is kept alongside base and length so the
	// state-dependent compares need no adder in front of them.
	logic [POS_W-1:0] window_base_q;
	logic [BUF_W-1:0] window_len_q;
	logic [END_W-1:0] window_end_q;
	logic [POS_W-1:0] src_pos_q;

	logic             hit;
	logic             overlap;
	logic [BUF_W-1:0] keep_cnt;
	logic [BUF_W-1:0] rd_count;
	logic [POS_W-1:0] rd_origin;
	logic             refill;

	assign advance   = !valid_s3 || !rsp_stall;
	assign req_stall = !advance;
	assign rsp_valid = valid_s3;
	assign rsp       = rsp_s3;

	// The source size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_size_q <= '0;
		end else if (cfg_wr_en) begin
			src_size_q <= cfg_wr_data;
		end
	end

	srwc_plan u_plan (
		.req      (req_s1),
		.src_size (src_size_q),
		.plan     (plan_comb)
	);

	// Stage two: compare against the live window and build the response.
	always_comb begin
		hit = (plan_s2.offset >= window_base_q) && (plan_s2.req_end <= window_end_q);
		overlap = (plan_s2.win_start >= window_base_q)
			&& ({1'b0, plan_s2.win_start} < window_end_q)
			&& (plan_s2.win_end >= window_end_q);
		if (overlap) begin
			keep_cnt  = BUF_W'(window_end_q - {1'b0, plan_s2.win_start});
			rd_origin = window_end_q[POS_W-1:0];
		end else begin
			keep_cnt  = '0;
			rd_origin = plan_s2.win_start;
		end
		rd_count = plan_s2.win_size - keep_cnt;
		refill   = valid_s2 && !plan_s2.empty && !hit;

		rsp_next                  = '0;
		rsp_next.new_window_start = window_base_q;
		rsp_next.new_window_size  = window_len_q;
		if (plan_s2.empty) begin
			rsp_next.status = STATUS_EMPTY;
		end else if (hit) begin
			rsp_next.status       = STATUS_HIT;
			rsp_next.buffer_index = BUF_W'(plan_s2.offset - window_base_q);
			rsp_next.avail_len    = plan_s2.avail_len;
		end else begin
			rsp_next.status           = STATUS_REFILL;
			rsp_next.buffer_index     = plan_s2.buf_off;
			rsp_next.avail_len        = plan_s2.avail_len;
			rsp_next.new_window_start = plan_s2.win_start;
			rsp_next.new_window_size  = plan_s2.win_size;
			if (overlap) begin
				rsp_next.keep_src   = BUF_W'(plan_s2.win_start - window_base_q);
				rsp_next.keep_count = keep_cnt;
			end
			if (rd_count != '0) begin
				rsp_next.seek_needed = (src_pos_q != rd_origin);
				rsp_next.read_pos    = rd_origin;
				rsp_next.read_dest   = keep_cnt;
				rsp_next.read_count  = rd_count;
			end
		end
	end

	// Pipeline valids and window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			valid_s3      <= 1'b0;
			window_base_q <= '0;
			window_len_q  <= '0;
			window_end_q  <= '0;
			src_pos_q     <= '0;
		end else if (advance) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (refill) begin
				window_base_q <= plan_s2.win_start;
				window_len_q  <= plan_s2.win_size;
				window_end_q  <= plan_s2.win_end;
				// A read always ends at the window end, kept or not.
				if (rd_count != '0) begin
					src_pos_q <= plan_s2.win_end[POS_W-1:0];
				end
			end
		end
	end

	// Payload registers; they only move with the pipeline.
	always_ff @(posedge clk) begin
		if (advance) begin
			req_s1  <= req;
			plan_s2 <= plan_comb;
			rsp_s3  <= rsp_next;
		end
	end

endmodule
